>>> rtl/cbts_pkg.sv
// Package for the CAN bit timing solver: status codes, microcode types and the control store.
// Used by can_bit_timing_solver_unit and cbts_divider. It depends on nothing else.
package cbts_pkg;

  // Shared divider operand width. This is the width of the peripheral clock register.
  localparam int DIV_W = 27;
  localparam int RATE_W = 24;
  localparam int SUM_W = 5;
  localparam int PC_W = 4;

  localparam logic [RATE_W-1:0] HIGH_RATE_BPS = 24'd1000000;
  localparam logic [SUM_W-1:0] SUM_HIGH_RATE = 5'd9;   // 10 quanta minus one
  localparam logic [SUM_W-1:0] SUM_LOW_RATE = 5'd16;   // 17 quanta minus one
  localparam logic [SUM_W-1:0] SUM_MIN = 5'd2;
  localparam logic [DIV_W-1:0] PRESC_MAX = 27'd1024;
  localparam logic [4:0] SEG1_MAX = 5'd16;
  localparam logic [4:0] SEG2_MAX = 5'd8;
  localparam logic [DIV_W-1:0] CLOCK_RESET = 27'd48000000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_INTERNAL = 2'd2
  } status_t;

  // Datapath operation of one microcode step.
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_ACCEPT,
    UOP_DIV_RATE,
    UOP_DIV_SUM,
    UOP_DEC_SUM,
    UOP_SEGS,
    UOP_DIV_CHECK,
    UOP_EMIT_OK,
    UOP_EMIT_INVALID,
    UOP_EMIT_INTERNAL
  } uop_t;

  // Branch condition of one microcode step.
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_RATE_ZERO,
    C_REM_ZERO,
    C_SUM_LOW,
    C_PRESC_BAD,
    C_CHECK_BAD
  } cond_t;

  typedef struct packed {
    uop_t            op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_result_t;

  // Program addresses.
  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_ZERO     = 4'd1;
  localparam logic [PC_W-1:0] PC_DIV_RATE = 4'd2;
  localparam logic [PC_W-1:0] PC_SEARCH   = 4'd3;
  localparam logic [PC_W-1:0] PC_SUM_LOW  = 4'd4;
  localparam logic [PC_W-1:0] PC_DEC      = 4'd5;
  localparam logic [PC_W-1:0] PC_FOUND    = 4'd6;
  localparam logic [PC_W-1:0] PC_CHECK    = 4'd7;
  localparam logic [PC_W-1:0] PC_VERIFY   = 4'd8;
  localparam logic [PC_W-1:0] PC_OK       = 4'd9;
  localparam logic [PC_W-1:0] PC_INVALID  = 4'd10;
  localparam logic [PC_W-1:0] PC_INTERNAL = 4'd11;

  // The control store. Every step either falls through or jumps when its condition holds.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      PC_IDLE:     w = '{op: UOP_ACCEPT,        cond: C_NEXT,      target: PC_IDLE};
      PC_ZERO:     w = '{op: UOP_NOP,           cond: C_RATE_ZERO, target: PC_INVALID};
      PC_DIV_RATE: w = '{op: UOP_DIV_RATE,      cond: C_NEXT,      target: PC_IDLE};
      PC_SEARCH:   w = '{op: UOP_DIV_SUM,       cond: C_REM_ZERO,  target: PC_FOUND};
      PC_SUM_LOW:  w = '{op: UOP_NOP,           cond: C_SUM_LOW,   target: PC_INVALID};
      PC_DEC:      w = '{op: UOP_DEC_SUM,       cond: C_ALWAYS,    target: PC_SEARCH};
      PC_FOUND:    w = '{op: UOP_SEGS,          cond: C_PRESC_BAD, target: PC_INVALID};
      PC_CHECK:    w = '{op: UOP_DIV_CHECK,     cond: C_NEXT,      target: PC_IDLE};
      PC_VERIFY:   w = '{op: UOP_NOP,           cond: C_CHECK_BAD, target: PC_INTERNAL};
      PC_OK:       w = '{op: UOP_EMIT_OK,       cond: C_ALWAYS,    target: PC_IDLE};
      PC_INVALID:  w = '{op: UOP_EMIT_INVALID,  cond: C_ALWAYS,    target: PC_IDLE};
      PC_INTERNAL: w = '{op: UOP_EMIT_INTERNAL, cond: C_ALWAYS,    target: PC_IDLE};
      default:     w = '{op: UOP_NOP,           cond: C_ALWAYS,    target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/cbts_divider.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
// It depends on cbts_pkg for the operand width and the result struct.
module cbts_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [cbts_pkg::DIV_W-1:0] dividend,
  input  logic [cbts_pkg::DIV_W-1:0] divisor,
  output cbts_pkg::div_result_t      res
);
  import cbts_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] diff;

  always_comb begin
    shifted  = {rem_r, quo_r[DIV_W-1]};
    diff     = {1'b0, shifted} - {2'b00, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = CNT_W'(DIV_W);
    end else if (cnt_r != '0) begin
      // The partial remainder always stays below the divisor, so it fits DIV_W bits.
      if (!diff[DIV_W+1]) begin
        rem_nxt = diff[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res.busy      = (cnt_r != '0);
  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule

>>> rtl/can_bit_timing_solver_unit.sv
// Top level of the CAN bit timing solver: a microcoded sequencer around one shared divider.
// It depends on cbts_pkg and instantiates cbts_divider.
//
// Usage: write the peripheral clock in hertz to the register at byte address 0 through the
// APB-style port while the block is idle. Then offer a requested bitrate as an input
// transaction (in_valid, in_target_bitrate). The block returns one result transaction with a
// status and the prescaler, SJW, BS1 and BS2 register fields, each minus one.
// The input side is stalled for the entire time that one bitrate is worked on. The block
// takes a new transaction only at the idle step of its program.
// A zero bitrate goes straight to the invalid result, with no divide. Otherwise the shared
// restoring divider does the work: each divide loads its operands, forms the 27 quotient
// bits one by one and then signals done. It runs once for clock/bitrate, once for every
// candidate quanta count, and, when the prescaler is in range, once more to check that
// clock divided by clock/bitrate gives back the bitrate.
// The result sits in an output register. The block accepts the next transaction while that
// result is still stalled. A second result waits at the emit step until the first is taken.
// Reset is synchronous and active low. It returns the program counter to the idle step,
// empties the output register and sets the clock register to 48 MHz.
module can_bit_timing_solver_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cbts_pkg::RATE_W-1:0] in_target_bitrate,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [9:0]                  out_prescaler_field,
  output logic [1:0]                  out_sync_jump_field,
  output logic [3:0]                  out_seg1_field,
  output logic [2:0]                  out_seg2_field
);
  import cbts_pkg::*;

  // The clock register is the only configuration state.
  logic [DIV_W-1:0] clock_r, clock_nxt;

  // Sequencer state.
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            div_wait_r, div_wait_nxt;

  // Datapath registers.
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [DIV_W-1:0]  pbs_r, pbs_nxt;      // clock / bitrate
  logic [DIV_W-1:0]  presc_r, presc_nxt;  // pbs / quanta for the latest candidate
  logic [SUM_W-1:0]  sum_r, sum_nxt;      // quanta per bit minus one
  logic [4:0]        seg1_r, seg1_nxt;
  logic [4:0]        seg2_r, seg2_nxt;
  logic              check_ok_r, check_ok_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  status_t    out_status_r, out_status_nxt;
  logic [9:0] out_presc_r, out_presc_nxt;
  logic [3:0] out_seg1_r, out_seg1_nxt;
  logic [2:0] out_seg2_r, out_seg2_nxt;

  ucode_t           uc;
  logic             is_div, is_emit, hold, cond_true;
  logic             div_start;
  logic [DIV_W-1:0] div_dividend, div_divisor;
  div_result_t      div_res;
  logic             seg_bad;
  logic [7:0]       seg1_near, seg1_trunc;
  logic [15:0]      sample_lhs, sample_rhs;
  logic             cfg_write;

  cbts_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  // Configuration port: pready is always high, and a write completes in the access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == 1'b0) ? {5'b0, clock_r} : 32'd0;

  always_comb begin
    clock_nxt = clock_r;
    if (cfg_write && (paddr[2] == 1'b0)) begin
      clock_nxt = pwdata[DIV_W-1:0];
    end
  end

  // Segment split toward an 87.5% sample point. Round to nearest first. If the sample point
  // then exceeds 90.0% (floor of the per-mill value above 900, which is the same as
  // 1000*(1+seg1) >= 901*(1+sum)), round toward zero instead.
  always_comb begin
    seg1_near  = (8'd7 * 8'(sum_r) + 8'd3) >> 3;
    seg1_trunc = (8'd7 * 8'(sum_r) - 8'd1) >> 3;
    sample_lhs = 16'd1000 * (16'd1 + 16'(seg1_near));
    sample_rhs = 16'd901 * (16'd1 + 16'(sum_r));
    seg_bad    = (seg1_r == 5'd0) || (seg1_r > SEG1_MAX) ||
                 (seg2_r == 5'd0) || (seg2_r > SEG2_MAX);
  end

  // Microcode decode and branch.
  always_comb begin
    uc      = ucode_rom(pc_r);
    is_div  = (uc.op == UOP_DIV_RATE) || (uc.op == UOP_DIV_SUM) ||
              (uc.op == UOP_DIV_CHECK);
    is_emit = (uc.op == UOP_EMIT_OK) || (uc.op == UOP_EMIT_INVALID) ||
              (uc.op == UOP_EMIT_INTERNAL);

    // A step holds while its divide is running, while no input is offered at the idle step,
    // or while an earlier result is still stalled in the output register.
    hold = (is_div && !div_res.done) ||
           ((uc.op == UOP_ACCEPT) && !in_valid) ||
           (is_emit && out_valid_r && out_stall);

    case (uc.cond)
      C_NEXT:      cond_true = 1'b0;
      C_ALWAYS:    cond_true = 1'b1;
      C_RATE_ZERO: cond_true = (rate_r == '0);
      C_REM_ZERO:  cond_true = (div_res.remainder == '0);
      C_SUM_LOW:   cond_true = (sum_r <= SUM_MIN);
      C_PRESC_BAD: cond_true = (presc_r == '0) || (presc_r > PRESC_MAX);
      C_CHECK_BAD: cond_true = !check_ok_r || seg_bad;
      default:     cond_true = 1'b0;
    endcase

    if (hold) begin
      pc_nxt = pc_r;
    end else if (cond_true) begin
      pc_nxt = uc.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end

    div_start    = is_div && !div_wait_r;
    div_wait_nxt = div_wait_r;
    if (div_start) begin
      div_wait_nxt = 1'b1;
    end else if (div_res.done) begin
      div_wait_nxt = 1'b0;
    end

    case (uc.op)
      UOP_DIV_SUM: begin
        div_dividend = pbs_r;
        div_divisor  = DIV_W'(sum_r) + DIV_W'(1);
      end
      UOP_DIV_CHECK: begin
        div_dividend = clock_r;
        div_divisor  = pbs_r;
      end
      default: begin
        div_dividend = clock_r;
        div_divisor  = DIV_W'(rate_r);
      end
    endcase
  end

  assign in_stall = (pc_r != PC_IDLE);

  // Datapath updates that each step performs.
  always_comb begin
    rate_nxt       = rate_r;
    pbs_nxt        = pbs_r;
    presc_nxt      = presc_r;
    sum_nxt        = sum_r;
    seg1_nxt       = seg1_r;
    seg2_nxt       = seg2_r;
    check_ok_nxt   = check_ok_r;
    out_status_nxt = out_status_r;
    out_presc_nxt  = out_presc_r;
    out_seg1_nxt   = out_seg1_r;
    out_seg2_nxt   = out_seg2_r;
    out_valid_nxt  = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (uc.op) inside
      UOP_ACCEPT: begin
        rate_nxt = in_target_bitrate;
        sum_nxt  = (in_target_bitrate >= HIGH_RATE_BPS) ? SUM_HIGH_RATE : SUM_LOW_RATE;
      end
      UOP_DIV_RATE: begin
        if (div_res.done) begin
          pbs_nxt = div_res.quotient;
        end
      end
      UOP_DIV_SUM: begin
        if (div_res.done) begin
          presc_nxt = div_res.quotient;
        end
      end
      UOP_DEC_SUM: begin
        sum_nxt = sum_r - 1'b1;
      end
      UOP_SEGS: begin
        if (sample_lhs >= sample_rhs) begin
          seg1_nxt = seg1_trunc[4:0];
        end else begin
          seg1_nxt = seg1_near[4:0];
        end
        seg2_nxt = sum_r - seg1_nxt;
      end
      UOP_DIV_CHECK: begin
        if (div_res.done) begin
          check_ok_nxt = (div_res.quotient == DIV_W'(rate_r));
        end
      end
      UOP_EMIT_OK, UOP_EMIT_INVALID, UOP_EMIT_INTERNAL: begin
        if (!hold) begin
          out_valid_nxt = 1'b1;
          if (uc.op == UOP_EMIT_OK) begin
            out_status_nxt = ST_OK;
            out_presc_nxt  = 10'(presc_r - DIV_W'(1));
            out_seg1_nxt   = 4'(seg1_r - 5'd1);
            out_seg2_nxt   = 3'(seg2_r - 5'd1);
          end else begin
            out_status_nxt = (uc.op == UOP_EMIT_INVALID) ? ST_INVALID : ST_INTERNAL;
            out_presc_nxt  = '0;
            out_seg1_nxt   = '0;
            out_seg2_nxt   = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r     <= CLOCK_RESET;
      pc_r        <= PC_IDLE;
      div_wait_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clock_r     <= clock_nxt;
      pc_r        <= pc_nxt;
      div_wait_r  <= div_wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rate_r       <= rate_nxt;
    pbs_r        <= pbs_nxt;
    presc_r      <= presc_nxt;
    sum_r        <= sum_nxt;
    seg1_r       <= seg1_nxt;
    seg2_r       <= seg2_nxt;
    check_ok_r   <= check_ok_nxt;
    out_status_r <= out_status_nxt;
    out_presc_r  <= out_presc_nxt;
    out_seg1_r   <= out_seg1_nxt;
    out_seg2_r   <= out_seg2_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_prescaler_field = out_presc_r;
  assign out_sync_jump_field = 2'd0;
  assign out_seg1_field      = out_seg1_r;
  assign out_seg2_field      = out_seg2_r;

  // A divide is never started while the divider is still running.
  assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_res.busy)
    else $error("divider started while busy");

  // The divider completes only for a step that is waiting for it.
  assert property (@(posedge clk) disable iff (!rst_n) div_res.done |-> div_wait_r)
    else $error("divider result with no waiting step");

  // A new result appears only after an emit step of the program.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(pc_r) == PC_OK || $past(pc_r) == PC_INVALID ||
                            $past(pc_r) == PC_INTERNAL))
    else $error("result produced outside an emit step");

  // A failing status carries all-zero register fields.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |->
      (out_presc_r == '0 && out_seg1_r == '0 && out_seg2_r == '0))
    else $error("nonzero fields with a failing status");

  // The quanta count stays between three and seventeen while the search runs.
  assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PC_SEARCH) |-> (sum_r >= SUM_MIN && sum_r <= SUM_LOW_RATE))
    else $error("quanta count out of range during search");

endmodule

>>> bench/can_bit_timing_solver_unit_tb.sv
// Self-checking testbench for can_bit_timing_solver_unit: bitrate requests in, bit timing out.
// Depends on cbts_pkg and the RTL of the block only; it reads no files.
`timescale 1ns / 100ps

module can_bit_timing_solver_unit_tb;
  import cbts_pkg::*;

  // Register map of the configuration port.
  localparam logic [2:0] REG_CLOCK_HZ = 3'd0;
  localparam logic [DIV_W-1:0] CLOCK_MASK = '1;
  localparam int CYCLE_LIMIT = 2000000;
  // Idle time at the end of the run; it outlasts the block's worst case for one bitrate.
  localparam int SETTLE_CYCLES = 600;
  localparam int unsigned SAMPLE_LIMIT_PERMILL = 900;
  localparam int unsigned PERMILL = 1000;

  // One result transaction as the block should return it.
  typedef struct {
    status_t    status;
    logic [9:0] prescaler;
    logic [1:0] sync_jump;
    logic [3:0] seg1;
    logic [2:0] seg2;
  } bit_timing_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [RATE_W-1:0] in_target_bitrate = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [9:0]  out_prescaler_field;
  logic [1:0]  out_sync_jump_field;
  logic [3:0]  out_seg1_field;
  logic [2:0]  out_seg2_field;

  // Our own copy of the clock register, updated whenever the bench writes it.
  logic [DIV_W-1:0] clock_setting = CLOCK_RESET;
  bit_timing_t expected_timing[$];
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;
  int error_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int ok_count = 0;
  int clock_phases = 0;
  int cycle_count = 0;

  can_bit_timing_solver_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_target_bitrate   (in_target_bitrate),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_prescaler_field (out_prescaler_field),
    .out_sync_jump_field (out_sync_jump_field),
    .out_seg1_field      (out_seg1_field),
    .out_seg2_field      (out_seg2_field)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("can_bit_timing_solver_unit test failed");
      $finish;
    end
  end

  // Computes the bit timing fields for one requested bitrate at a given peripheral clock.
  // The search walks the quanta count down from the rate-dependent maximum to three, and
  // the first count that divides clock/bitrate exactly wins.
  function automatic bit_timing_t solve_bit_timing(input logic [DIV_W-1:0] clock_hz,
                                                   input logic [RATE_W-1:0] rate);
    bit_timing_t r;
    int unsigned per_bit, sum, presc, seg1, seg2;
    r = '{status: ST_INVALID, prescaler: '0, sync_jump: '0, seg1: '0, seg2: '0};
    if (rate == 0) return r;
    sum = 32'((rate >= HIGH_RATE_BPS) ? SUM_HIGH_RATE : SUM_LOW_RATE);
    per_bit = clock_hz / rate;
    while ((per_bit % (sum + 1)) != 0) begin
      if (sum <= SUM_MIN) return r;
      sum--;
    end
    presc = per_bit / (sum + 1);
    if (presc < 1 || presc > PRESC_MAX) return r;
    // Aim for an 87.5% sample point, rounding to nearest, and fall back to rounding
    // toward zero when that would push the sample point past 90%.
    seg1 = (7 * sum + 3) / 8;
    if ((PERMILL * (seg1 + 1)) / (sum + 1) > SAMPLE_LIMIT_PERMILL) seg1 = (7 * sum - 1) / 8;
    seg2 = sum - seg1;
    if (rate != clock_hz / (presc * (sum + 1)) || seg1 < 1 || seg1 > SEG1_MAX ||
        seg2 < 1 || seg2 > SEG2_MAX) begin
      r.status = ST_INTERNAL;
      return r;
    end
    r.status = ST_OK;
    r.prescaler = 10'(presc - 1);
    r.seg1 = 4'(seg1 - 1);
    r.seg2 = 3'(seg2 - 1);
    return r;
  endfunction

  function automatic int draw_wait(input bit enabled);
    return enabled ? int'($urandom_range(0, 6)) : 0;
  endfunction

  // Offers one bitrate request and records the expected result once the block takes it.
  // Valid is only lowered when an idle gap is drawn, so back-to-back requests keep it high.
  task automatic send_rate(input logic [RATE_W-1:0] rate);
    bit_timing_t want;
    int gap;
    want = solve_bit_timing(clock_setting, rate);
    gap = draw_wait(in_gaps_on);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_target_bitrate <= rate;
    do @(posedge clk); while (in_stall);
    expected_timing.push_back(want);
    sent_count++;
  endtask

  // Every request yields exactly one result, so an empty queue means the block is idle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_timing.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Reads the clock register back and compares it with our copy.
  task automatic check_clock_register();
    logic [31:0] seen;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_CLOCK_HZ;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    seen = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (seen !== 32'(clock_setting)) begin
      $error("clock_hz readback: expected %0d, actual %0d", clock_setting, seen);
      error_count++;
    end
  endtask

  // Writes the clock register through a setup and an access cycle, then reads it back.
  // Only called with the block idle.
  task automatic write_clock(input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_CLOCK_HZ;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    clock_setting = value[DIV_W-1:0] & CLOCK_MASK;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    check_clock_register();
    clock_phases++;
  endtask

  // Requests at the reset clock of 48 MHz, before the register has ever been written:
  // zero, the smallest and largest bitrates, both sides of the 1 Mbps quanta switch,
  // a rate that divides the clock exactly and a rate that divides it unevenly.
  task automatic test_reset_clock_rates();
    check_clock_register();
    send_rate(24'd0);
    send_rate(24'd1);
    send_rate(24'hFFFFFF);
    send_rate(HIGH_RATE_BPS);
    send_rate(HIGH_RATE_BPS - 24'd1);
    send_rate(24'd500000);
    send_rate(24'd46875);
    send_rate(24'd83333);
    wait_idle();
  endtask

  // Register extremes, then the corner cases of the solver that need a special clock.
  task automatic test_corner_cases();
    // A clock of zero gives a zero quotient, hence no prescaler.
    write_clock(32'd0);
    send_rate(24'd1);
    wait_idle();
    write_clock(32'(CLOCK_MASK));
    // Eight quanta at prescaler one hit the top bitrate exactly.
    send_rate(24'hFFFFFF);
    send_rate(24'd1);
    wait_idle();
    // Three quanta: nearest rounding would leave segment two empty, so the split falls
    // back to rounding toward zero. Then no divisor at all, then clock below bitrate.
    write_clock(32'd3);
    send_rate(24'd1);
    send_rate(24'd2);
    send_rate(24'd4);
    wait_idle();
    // 100 / 30 truncates to 3 quanta, but 100 / 3 is not 30: an inexact bitrate.
    write_clock(32'd100);
    send_rate(24'd30);
    send_rate(24'd100);
    wait_idle();
    // 1024 * 17 * 1000: prescaler exactly at its limit, one past it, and 17 quanta at
    // 1.024 Mbps, which the ten-quanta limit above 1 Mbps rules out.
    write_clock(32'd17408000);
    send_rate(24'd1000);
    send_rate(24'd999);
    send_rate(24'd1024000);
    wait_idle();
  endtask

  // Mostly clock/(prescaler*quanta) for a random prescaler and quanta count, with the rest
  // near misses, arbitrary values, the 1 Mbps region, rates at or above the clock,
  // zero and very low rates.
  function automatic logic [RATE_W-1:0] pick_rate(input logic [DIV_W-1:0] clock_hz);
    int unsigned sel, quanta, presc, value;
    sel = $urandom_range(0, 99);
    quanta = $urandom_range(3, 17);
    presc = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 64);
    value = clock_hz / (presc * quanta);
    if (sel < 55) return value[RATE_W-1:0];
    if (sel < 65) return RATE_W'(value + $urandom_range(0, 1) * 2 - 1);
    if (sel < 80) return RATE_W'($urandom());
    if (sel < 88) return RATE_W'($urandom_range(990000, 1010000));
    if (sel < 93) return RATE_W'(clock_hz + $urandom_range(0, 1000));
    if (sel < 96) return '0;
    return RATE_W'($urandom_range(1, 1000));
  endfunction

  // One clock setting with a burst of random requests. The idling mode rotates with the
  // phase so that some phases run with no gaps on one side or on both.
  task automatic test_random_phase(input logic [31:0] clock_hz, input int count,
                                   input int phase);
    write_clock(clock_hz);
    in_gaps_on = (phase % 4) inside {0, 1};
    out_stalls_on = (phase % 4) inside {0, 2};
    repeat (count) send_rate(pick_rate(clock_setting));
    wait_idle();
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  // Result side: a random stall before each result transaction, then the field checks
  // against the oldest outstanding expectation.
  initial begin : result_checker
    bit_timing_t want;
    int hold;
    wait (rst_n === 1'b1);
    forever begin
      hold = draw_wait(out_stalls_on);
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      if (expected_timing.size() == 0) begin
        $error("unexpected result transaction with status %0d", out_status);
        error_count++;
      end else begin
        want = expected_timing.pop_front();
        checked_count++;
        if (want.status == ST_OK) ok_count++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          error_count++;
        end
        if (out_prescaler_field !== want.prescaler) begin
          $error("prescaler_field: expected %0d, actual %0d", want.prescaler,
                 out_prescaler_field);
          error_count++;
        end
        if (out_sync_jump_field !== want.sync_jump) begin
          $error("sync_jump_field: expected %0d, actual %0d", want.sync_jump,
                 out_sync_jump_field);
          error_count++;
        end
        if (out_seg1_field !== want.seg1) begin
          $error("seg1_field: expected %0d, actual %0d", want.seg1, out_seg1_field);
          error_count++;
        end
        if (out_seg2_field !== want.seg2) begin
          $error("seg2_field: expected %0d, actual %0d", want.seg2, out_seg2_field);
          error_count++;
        end
      end
    end
  end

  // Main sequence: reset once, directed cases, then random phases over several clocks.
  initial begin : main_sequence
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_clock_rates();
    test_corner_cases();
    test_random_phase(32'(CLOCK_RESET), 70, 0);
    test_random_phase(32'd100000000, 70, 1);
    test_random_phase(32'd80000000, 70, 2);
    test_random_phase(32'd8000000, 70, 3);
    test_random_phase(32'(CLOCK_MASK), 70, 4);
    test_random_phase($urandom_range(1, 32'(CLOCK_MASK)), 70, 5);
    test_random_phase($urandom_range(1, 100000), 70, 6);
    test_random_phase(32'd36000000, 70, 7);
    // Any late or extra result would show up during this settling time.
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Solved %0d bitrate requests (%0d with a valid timing) over %0d clock settings,",
             checked_count, ok_count, clock_phases);
    $display("with random input gaps and output stalls; %0d mismatches.", error_count);
    if (error_count == 0 && sent_count == checked_count) begin
      $display("can_bit_timing_solver_unit test passed");
    end else begin
      $display("can_bit_timing_solver_unit test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cbts_pkg.sv
rtl/cbts_divider.sv
rtl/can_bit_timing_solver_unit.sv
bench/can_bit_timing_solver_unit_tb.sv
